// ----- rtl/olad_pkg.sv -----
// ----------------------------------------------------------------------------
// olad_pkg
// Shared constants, codes and types of the ordered list block.
// ----------------------------------------------------------------------------
`default_nettype none

package olad_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  // wide enough to hold DEPTH itself
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ENTRY    = 3'd4;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbour's value
    logic load;   // take the shared load value (wins over shift)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/olad_cell.sv -----
// ----------------------------------------------------------------------------
// olad_cell
// One list position: holds a value and takes either its neighbour's value
// or the shared load value.
// ----------------------------------------------------------------------------
`default_nettype none

module olad_cell (
  input  wire                                clk_i,
  input  wire olad_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [olad_pkg::DATA_W-1:0]   load_data_i,
  input  wire logic [olad_pkg::DATA_W-1:0]   next_data_i,
  output logic      [olad_pkg::DATA_W-1:0]   data_o
);

  logic [olad_pkg::DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/ordered_list_append_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_list_append_delete
// Ordered list of signed 32-bit values kept in a row of cells, head in cell 0.
// Delete and dump rotate the list through the head cell.
// ----------------------------------------------------------------------------
//
//   channel | signals                         | direction | transfer when
//   --------+---------------------------------+-----------+-------------------------
//   in      | func_i, value_i                 | in        | in_valid_i & in_ready_o
//   out     | status_o, entry_o, last_o       | out       | out_valid_o & out_ready_i
//
// append: written straight into the tail cell
// delete: one head compare per cycle while the output is free, as the list rotates once
// dump: one result per cycle from the head cell while the output is free
// the single head comparator and the output register pace delete and dump
// reset empties the list (count to zero); cell contents are not cleared
// an output stall freezes the rotation; a new request is taken only when idle
`default_nettype none

module ordered_list_append_delete (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   func_i,
  input  wire logic signed [olad_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic      [2:0]                   status_o,
  output logic signed [olad_pkg::DATA_W-1:0] entry_o,
  output logic                              last_o
);

  localparam int unsigned CW = olad_pkg::CNT_W;
  localparam int unsigned DW = olad_pkg::DATA_W;
  localparam int unsigned N  = olad_pkg::DEPTH;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DUMP = 3'b010,
    S_DEL  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] len_q, len_d;
  logic          found_q, found_d;
  logic [DW-1:0] val_q, val_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q, status_d;
  logic [DW-1:0] entry_q, entry_d;
  logic          last_q, last_d;

  logic [DW-1:0] cell_data [N];
  logic [DW-1:0] load_data;
  logic [CW-1:0] load_pos;
  logic          load_en;
  logic          shift_en;
  olad_pkg::cell_ctrl_t cell_ctrl [N];

  logic out_free, accept, step, hit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign step       = out_free && (state_q != S_IDLE);
  assign hit        = !found_q && (cell_data[0] == val_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    len_d       = len_q;
    found_d     = found_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    entry_d     = entry_q;
    last_d      = last_q;
    load_data   = cell_data[0];
    load_pos    = count_q;
    load_en     = 1'b0;
    shift_en    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = olad_pkg::ST_DONE;
          entry_d     = '0;
          last_d      = 1'b1;
          case (func_i)
            olad_pkg::FUNC_APPEND: begin
              if (count_q == CW'(N)) begin
                status_d = olad_pkg::ST_FULL;
              end else begin
                load_en   = 1'b1;
                load_data = value_i;
                count_d   = count_q + CW'(1);
              end
            end
            olad_pkg::FUNC_DELETE: begin
              if (count_q == '0) begin
                status_d = olad_pkg::ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                rem_d       = count_q;
                len_d       = count_q;
                found_d     = 1'b0;
                val_d       = value_i;
                state_d     = S_DEL;
              end
            end
            olad_pkg::FUNC_DUMP: begin
              if (count_q == '0) begin
                status_d = olad_pkg::ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                rem_d       = count_q;
                state_d     = S_DUMP;
              end
            end
            default: begin
              status_d = olad_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (step) begin
          // head goes out and wraps round to the tail
          shift_en    = 1'b1;
          load_en     = 1'b1;
          load_pos    = count_q - CW'(1);
          out_valid_d = 1'b1;
          status_d    = olad_pkg::ST_ENTRY;
          entry_d     = cell_data[0];
          last_d      = (rem_q == CW'(1));
          rem_d       = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_DEL: begin
        if (step) begin
          shift_en = 1'b1;
          load_pos = len_q - CW'(1);
          if (hit) begin
            // first match is dropped, the rest close up
            found_d = 1'b1;
            len_d   = len_q - CW'(1);
          end else begin
            load_en = 1'b1;
          end
          rem_d = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            out_valid_d = 1'b1;
            status_d    = (found_q || hit) ? olad_pkg::ST_DONE : olad_pkg::ST_NOTFOUND;
            entry_d     = '0;
            last_d      = 1'b1;
            count_d     = len_d;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_ctrl[i].shift = shift_en;
      cell_ctrl[i].load  = load_en && (load_pos == CW'(i));
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [DW-1:0] next_data;
    if (g == N - 1) begin : g_end
      assign next_data = cell_data[g];
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    olad_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .load_data_i (load_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      len_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      len_q       <= len_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign entry_o     = entry_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/olad_checker.sv -----
// ----------------------------------------------------------------------------
// olad_checker
// Port-level checks of the ordered list block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olad_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire logic [1:0]                  func_i,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire logic [2:0]                  status_o,
  input wire logic [olad_pkg::DATA_W-1:0] entry_o,
  input wire                              last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // status results carry no entry and close their request
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != olad_pkg::ST_ENTRY) |-> (entry_o == '0) && last_o)
    else $error("status result with entry or without last");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == olad_pkg::ST_DONE) || (status_o == olad_pkg::ST_FULL) ||
                    (status_o == olad_pkg::ST_EMPTY) || (status_o == olad_pkg::ST_NOTFOUND) ||
                    (status_o == olad_pkg::ST_ENTRY))
    else $error("unknown status code");

  // append answers in the next cycle
  a_append_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == olad_pkg::FUNC_APPEND) |=>
      out_valid_o && last_o &&
      ((status_o == olad_pkg::ST_DONE) || (status_o == olad_pkg::ST_FULL)))
    else $error("append result missing");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .entry_o     (entry_o),
  .last_o      (last_o)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list block. A table of directed
// requests covers empty, full, duplicate and head/tail deletes. Random
// append, delete and dump traffic follows, with idle gaps on both channels.
// Every result is checked against a shadow copy of the list, or against the known answer in the table.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM   = 288;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned TAIL_WAIT  = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry;
    logic        last;
  } list_result_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        typed;   // status below is the known answer
    logic [2:0]  status;
  } list_req_t;

  localparam int unsigned N_PLAN = 22;
  localparam list_req_t PLAN [N_PLAN] = '{
    '{olad_pkg::FUNC_DUMP,   32'h0000_0000, 5'd1,  1'b1, olad_pkg::ST_EMPTY},
    '{olad_pkg::FUNC_DELETE, 32'h0000_0005, 5'd1,  1'b1, olad_pkg::ST_EMPTY},
    '{FUNC_UNUSED,           32'hffff_ffff, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h8000_0000, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h7fff_ffff, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h0000_0000, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'hffff_ffff, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DUMP,   32'h1234_5678, 5'd1,  1'b0, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DELETE, 32'h1234_5678, 5'd1,  1'b1, olad_pkg::ST_NOTFOUND},
    '{olad_pkg::FUNC_DELETE, 32'h7fff_ffff, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h8000_0000, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DELETE, 32'h8000_0000, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DUMP,   32'hffff_ffff, 5'd1,  1'b0, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h5555_5555, 5'd13, 1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'haaaa_aaaa, 5'd1,  1'b1, olad_pkg::ST_FULL},
    '{olad_pkg::FUNC_DUMP,   32'h0000_0000, 5'd1,  1'b0, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DELETE, 32'hffff_ffff, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_APPEND, 32'h0000_1234, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DELETE, 32'h0000_1234, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DELETE, 32'h5555_5555, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{FUNC_UNUSED,           32'h0000_0000, 5'd1,  1'b1, olad_pkg::ST_DONE},
    '{olad_pkg::FUNC_DUMP,   32'h0000_0000, 5'd1,  1'b0, olad_pkg::ST_DONE}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i      = olad_pkg::FUNC_APPEND;
  logic [31:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] entry_o;
  logic        last_o;

  // known answer travelling with the request on offer
  logic        req_typed   = 1'b0;
  logic [2:0]  req_status  = olad_pkg::ST_DONE;

  logic [31:0]  shadow_list [olad_pkg::DEPTH];
  int unsigned  shadow_count = 0;
  list_result_t pending_results [$];

  int unsigned n_mismatch = 0;
  int unsigned n_offered  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  ordered_list_append_delete u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .entry_o     (entry_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_result(input logic [2:0] st, input logic [31:0] ent,
                                     input logic lst);
    list_result_t res;
    res.status = st;
    res.entry  = ent;
    res.last   = lst;
    pending_results.push_back(res);
  endfunction

  // applies one request to the shadow list and queues the results it causes
  function automatic void step_list(input logic [1:0] func, input logic [31:0] value);
    int unsigned pos;
    pos = shadow_count;
    case (func)
      olad_pkg::FUNC_APPEND: begin
        if (shadow_count >= olad_pkg::DEPTH) begin
          add_result(olad_pkg::ST_FULL, '0, 1'b1);
        end else begin
          shadow_list[shadow_count] = value;
          shadow_count++;
          add_result(olad_pkg::ST_DONE, '0, 1'b1);
        end
      end
      olad_pkg::FUNC_DELETE: begin
        if (shadow_count == 0) begin
          add_result(olad_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            if (pos == shadow_count && shadow_list[i] == value) pos = i;
          if (pos == shadow_count) begin
            add_result(olad_pkg::ST_NOTFOUND, '0, 1'b1);
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++)
              shadow_list[i] = shadow_list[i + 1];
            shadow_count--;
            add_result(olad_pkg::ST_DONE, '0, 1'b1);
          end
        end
      end
      olad_pkg::FUNC_DUMP: begin
        if (shadow_count == 0) begin
          add_result(olad_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            add_result(olad_pkg::ST_ENTRY, shadow_list[i], (i + 1 == shadow_count));
        end
      end
      default: add_result(olad_pkg::ST_DONE, '0, 1'b1);
    endcase
  endfunction

  // both channels observed here, request side first
  always @(posedge clk_i) begin : monitor
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_list(func_i, value_i);
        if (req_typed) begin
          want.status = req_status;
          want.entry  = '0;
          want.last   = 1'b1;
          pending_results[pending_results.size() - 1] = want;
        end
      end
      if (out_valid_o && out_ready_i) begin
        got.status = status_o;
        got.entry  = entry_o;
        got.last   = last_o;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d entry %h last %b",
                                    got.status, got.entry, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            report_mismatch($sformatf("got status %0d entry %h last %b, want %0d %h %b",
                                      got.status, got.entry, got.last,
                                      want.status, want.entry, want.last));
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off while requests keep coming
  always @(posedge clk_i) begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    if (!hold_done && n_offered >= 80) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic offer(input logic [1:0] f, input logic [31:0] v, input logic typed,
                       input logic [2:0] st);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    req_typed  <= typed;
    req_status <= st;
    n_offered++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] pool [8];
    logic [1:0]  f;
    logic [31:0] v;
    int unsigned r;
    int unsigned w_append;
    int unsigned blk;
    pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h5555_5555, 32'haaaa_aaaa, 32'h0000_00ff};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_PLAN; i++)
      for (int j = 0; j < PLAN[i].reps; j++)
        offer(PLAN[i].func, PLAN[i].value, PLAN[i].typed, PLAN[i].status);
    drain();

    for (int k = 0; k < N_RANDOM; k++) begin
      blk = k / 40;
      quiet = (blk % 4 == 3);
      // the append weight swings the list between empty and full
      case (blk % 3)
        0:       w_append = 70;
        1:       w_append = 45;
        default: w_append = 25;
      endcase
      r = $urandom_range(0, 99);
      if (r < w_append) f = olad_pkg::FUNC_APPEND;
      else if (r < w_append + (100 - w_append) * 6 / 10) f = olad_pkg::FUNC_DELETE;
      else if (r < 98) f = olad_pkg::FUNC_DUMP;
      else f = FUNC_UNUSED;
      if ($urandom_range(0, 3) != 0) begin
        v = pool[$urandom_range(0, 7)];
      end else begin
        v = $urandom;
        pool[$urandom_range(0, 7)] = v;
      end
      if (k == 160) drain();
      offer(f, v, 1'b0, olad_pkg::ST_DONE);
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/olad_pkg.sv
rtl/olad_cell.sv
rtl/ordered_list_append_delete.sv
rtl/olad_checker.sv
tb/sv/tb.sv
